// ===== src/fifo_thread_scheduler_with_mutexes_macros.svh =====
// Assertion macros shared by the checker. Each use stands on a line of its own.
`ifndef FIFO_THREAD_SCHEDULER_WITH_MUTEXES_MACROS_SVH
`define FIFO_THREAD_SCHEDULER_WITH_MUTEXES_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fts_pkg.sv =====
package fts_pkg;

  localparam logic [2:0] CMD_SPAWN  = 3'd0;
  localparam logic [2:0] CMD_YIELD  = 3'd1;
  localparam logic [2:0] CMD_LOCK   = 3'd2;
  localparam logic [2:0] CMD_UNLOCK = 3'd3;
  localparam logic [2:0] CMD_EXIT   = 3'd4;
  localparam logic [2:0] CMD_TICK   = 3'd5;
  localparam logic [2:0] CMD_JOY    = 3'd6;
  localparam logic [2:0] CMD_READ   = 3'd7;

  // Depth of the command queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    OP_SPAWN,
    OP_YIELD,
    OP_LOCK,
    OP_UNLOCK,
    OP_EXIT,
    OP_TICK,
    OP_JOY,
    OP_READ,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [1:0] mutex;
  } op_t;

  typedef enum logic [1:0] {
    QS_FREE,
    QS_READY,
    QS_WAIT
  } qsel_t;

endpackage

// ===== src/fts_front.sv =====
module fts_front #(
  parameter int MUTEXES = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    cmd,
  input  logic [1:0]    mutex_index,
  output logic          q_valid,
  input  logic          q_take,
  output fts_pkg::op_t  q_op
);
  import fts_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_t           entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  op_t           decoded;
  logic          mutex_ok;
  logic          push;
  logic          pop;

  assign mutex_ok = int'(mutex_index) < MUTEXES;

  // A lock or unlock on a mutex that does not exist is turned into a no-op here.
  always_comb begin
    decoded.mutex = mutex_index;
    unique case (cmd)
      CMD_SPAWN:  decoded.kind = OP_SPAWN;
      CMD_YIELD:  decoded.kind = OP_YIELD;
      CMD_LOCK:   decoded.kind = mutex_ok ? OP_LOCK : OP_NOP;
      CMD_UNLOCK: decoded.kind = mutex_ok ? OP_UNLOCK : OP_NOP;
      CMD_EXIT:   decoded.kind = OP_EXIT;
      CMD_TICK:   decoded.kind = OP_TICK;
      CMD_JOY:    decoded.kind = OP_JOY;
      CMD_READ:   decoded.kind = OP_READ;
      default:    decoded.kind = OP_NOP;
    endcase
  end

  assign in_stall = (count == CW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_take;
  assign q_op     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

endmodule

// ===== src/fts_back.sv =====
module fts_back #(
  parameter int THREADS = 4,
  parameter int MUTEXES = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_take,
  input  fts_pkg::op_t  q_op,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    running,
  output logic [1:0]    new_thread,
  output logic [15:0]   ticks,
  output logic          panic
);
  import fts_pkg::*;

  localparam int IW = $clog2(THREADS + 1);
  localparam int MW = (MUTEXES > 1) ? $clog2(MUTEXES) : 1;

  logic [IW-1:0] link [THREADS+1];

  logic [IW-1:0] free_head, free_head_next;
  logic [IW-1:0] free_tail, free_tail_next;
  logic          free_ne, free_ne_next;
  logic [IW-1:0] ready_head, ready_head_next;
  logic [IW-1:0] ready_tail, ready_tail_next;
  logic          ready_ne, ready_ne_next;
  logic [IW-1:0] wait_head [MUTEXES];
  logic [IW-1:0] wait_head_next [MUTEXES];
  logic [IW-1:0] wait_tail [MUTEXES];
  logic [IW-1:0] wait_tail_next [MUTEXES];
  logic          wait_ne [MUTEXES];
  logic          wait_ne_next [MUTEXES];
  logic [MUTEXES-1:0] locked, locked_next;
  logic [IW-1:0] cur, cur_next;
  logic [15:0]   tick_count, tick_count_next;
  logic          joy, joy_next;
  logic          panic_flag, panic_next;
  logic [IW-1:0] new_next;
  logic [15:0]   ticks_next;

  logic [MW-1:0] mi;
  logic          fire;
  logic          yield_req;
  logic          push_en;
  qsel_t         push_sel;
  logic [IW-1:0] push_id;
  logic          pop_en;
  qsel_t         pop_sel;
  logic          fwd_en;
  logic          lw_en;
  logic [IW-1:0] lw_addr;
  logic [IW-1:0] lw_data;
  logic [IW-1:0] pop_id;
  logic [IW-1:0] pop_tail;
  logic [IW-1:0] link_rd;

  assign mi     = MW'(q_op.mutex);
  assign q_take = !out_valid || !out_stall;
  assign fire   = q_valid && q_take;

  // Every command is one enqueue followed by one dequeue at most. The link
  // written by the enqueue is forwarded to the dequeue in the same cycle, except on a spawn.
  always_comb begin
    free_head_next  = free_head;
    free_tail_next  = free_tail;
    free_ne_next    = free_ne;
    ready_head_next = ready_head;
    ready_tail_next = ready_tail;
    ready_ne_next   = ready_ne;
    wait_head_next  = wait_head;
    wait_tail_next  = wait_tail;
    wait_ne_next    = wait_ne;
    locked_next     = locked;
    cur_next        = cur;
    tick_count_next = tick_count;
    joy_next        = joy;
    panic_next      = panic_flag;
    new_next        = '0;
    ticks_next      = '0;
    yield_req       = 1'b0;
    push_en         = 1'b0;
    push_sel        = QS_READY;
    push_id         = cur;
    pop_en          = 1'b0;
    pop_sel         = QS_READY;
    fwd_en          = 1'b1;
    lw_en           = 1'b0;
    lw_addr         = '0;
    pop_id          = cur;
    pop_tail        = cur;
    link_rd         = '0;

    if (!panic_flag) begin
      unique case (q_op.kind)
        OP_SPAWN: begin
          if (!free_ne) begin
            panic_next = 1'b1;
          end else begin
            // The free head is appended to the ready queue and popped from the free chain.
            push_en  = 1'b1;
            push_sel = QS_READY;
            push_id  = free_head;
            pop_en   = 1'b1;
            pop_sel  = QS_FREE;
            fwd_en   = 1'b0;
            new_next = free_head;
          end
        end
        OP_YIELD: yield_req = 1'b1;
        OP_LOCK: begin
          if (!locked[mi]) begin
            locked_next[mi] = 1'b1;
          end else if (!ready_ne) begin
            panic_next = 1'b1;
          end else begin
            push_en  = 1'b1;
            push_sel = QS_WAIT;
            pop_en   = 1'b1;
            pop_sel  = QS_READY;
          end
        end
        OP_UNLOCK: begin
          if (!wait_ne[mi]) begin
            locked_next[mi] = 1'b0;
          end else begin
            // The lock stays set and passes to the first waiter.
            push_en  = 1'b1;
            push_sel = QS_READY;
            pop_en   = 1'b1;
            pop_sel  = QS_WAIT;
          end
        end
        OP_EXIT: begin
          if (!ready_ne) begin
            panic_next = 1'b1;
          end else begin
            // The initial thread owns no slot and is not returned.
            push_en  = (cur < IW'(THREADS));
            push_sel = QS_FREE;
            pop_en   = 1'b1;
            pop_sel  = QS_READY;
          end
        end
        OP_TICK: begin
          tick_count_next = tick_count + 16'd1;
          yield_req       = 1'b1;
        end
        OP_JOY: begin
          if (!joy) begin
            joy_next  = 1'b1;
            yield_req = 1'b1;
          end else begin
            joy_next = 1'b0;
          end
        end
        OP_READ: begin
          ticks_next      = tick_count;
          tick_count_next = '0;
        end
        default: ;
      endcase

      if (yield_req) begin
        push_en  = 1'b1;
        push_sel = QS_READY;
        pop_en   = 1'b1;
        pop_sel  = QS_READY;
      end
    end

    if (push_en) begin
      unique case (push_sel)
        QS_FREE: begin
          lw_en   = free_ne;
          lw_addr = free_tail;
          if (!free_ne) begin
            free_head_next = push_id;
          end
          free_tail_next = push_id;
          free_ne_next   = 1'b1;
        end
        QS_READY: begin
          lw_en   = ready_ne;
          lw_addr = ready_tail;
          if (!ready_ne) begin
            ready_head_next = push_id;
          end
          ready_tail_next = push_id;
          ready_ne_next   = 1'b1;
        end
        default: begin
          lw_en   = wait_ne[mi];
          lw_addr = wait_tail[mi];
          if (!wait_ne[mi]) begin
            wait_head_next[mi] = push_id;
          end
          wait_tail_next[mi] = push_id;
          wait_ne_next[mi]   = 1'b1;
        end
      endcase
    end
    lw_data = push_id;

    if (pop_en) begin
      unique case (pop_sel)
        QS_FREE: begin
          pop_id   = free_head_next;
          pop_tail = free_tail_next;
        end
        QS_READY: begin
          pop_id   = ready_head_next;
          pop_tail = ready_tail_next;
        end
        default: begin
          pop_id   = wait_head_next[mi];
          pop_tail = wait_tail_next[mi];
        end
      endcase

      link_rd = (fwd_en && lw_en && lw_addr == pop_id) ? lw_data : link[pop_id];

      unique case (pop_sel)
        QS_FREE: begin
          if (pop_id == pop_tail) begin
            free_ne_next = 1'b0;
          end else begin
            free_head_next = link_rd;
          end
        end
        QS_READY: begin
          if (pop_id == pop_tail) begin
            ready_ne_next = 1'b0;
          end else begin
            ready_head_next = link_rd;
          end
        end
        default: begin
          if (pop_id == pop_tail) begin
            wait_ne_next[mi] = 1'b0;
          end else begin
            wait_head_next[mi] = link_rd;
          end
        end
      endcase

      if (pop_sel != QS_FREE) begin
        cur_next = pop_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= THREADS; i++) begin
        link[i] <= (i < THREADS - 1) ? IW'(i + 1) : '0;
      end
      free_head  <= '0;
      free_tail  <= IW'(THREADS - 1);
      free_ne    <= 1'b1;
      ready_head <= '0;
      ready_tail <= '0;
      ready_ne   <= 1'b0;
      for (int m = 0; m < MUTEXES; m++) begin
        wait_head[m] <= '0;
        wait_tail[m] <= '0;
        wait_ne[m]   <= 1'b0;
      end
      locked     <= '0;
      cur        <= IW'(THREADS);
      tick_count <= '0;
      joy        <= 1'b0;
      panic_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        if (lw_en) begin
          link[lw_addr] <= lw_data;
        end
        free_head  <= free_head_next;
        free_tail  <= free_tail_next;
        free_ne    <= free_ne_next;
        ready_head <= ready_head_next;
        ready_tail <= ready_tail_next;
        ready_ne   <= ready_ne_next;
        wait_head  <= wait_head_next;
        wait_tail  <= wait_tail_next;
        wait_ne    <= wait_ne_next;
        locked     <= locked_next;
        cur        <= cur_next;
        tick_count <= tick_count_next;
        joy        <= joy_next;
        panic_flag <= panic_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      running    <= 3'(cur_next);
      new_thread <= 2'(new_next);
      ticks      <= ticks_next;
      panic      <= panic_next;
    end
  end

endmodule

// ===== src/fifo_thread_scheduler_with_mutexes.sv =====
// A result is registered, valid in the cycle after the back end takes its command;
// the front queue holds two commands. Throughput: one command per cycle while the
// result port does not stall, set by the back end, which executes a whole command
// (one enqueue, one dequeue, one link read) combinationally.
// Reset (rst, synchronous): all slots back on the free chain, other queues
// empty, initial thread running, counters and flags cleared, queued commands dropped.
module fifo_thread_scheduler_with_mutexes #(
  parameter int THREADS = 4,
  parameter int MUTEXES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [1:0]  mutex_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  running,
  output logic [1:0]  new_thread,
  output logic [15:0] ticks,
  output logic        panic
);
  import fts_pkg::*;

  logic q_valid;
  logic q_take;
  op_t  q_op;

  fts_front #(
    .MUTEXES(MUTEXES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .mutex_index(mutex_index),
    .q_valid    (q_valid),
    .q_take     (q_take),
    .q_op       (q_op)
  );

  fts_back #(
    .THREADS(THREADS),
    .MUTEXES(MUTEXES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_op      (q_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .running   (running),
    .new_thread(new_thread),
    .ticks     (ticks),
    .panic     (panic)
  );

endmodule

// ===== src/fts_checker.sv =====
`include "fifo_thread_scheduler_with_mutexes_macros.svh"

module fts_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  running,
  input logic [1:0]  new_thread,
  input logic [15:0] ticks,
  input logic        panic
);

  // Once halted, the scheduler keeps reporting panic and never switches threads.
  `FTS_ASSERT_NEXT(ast_panic_sticky, out_valid && !out_stall && panic, !out_valid || panic, "panic dropped after being reported")
  `FTS_ASSERT_NEXT(ast_halt_keeps_thread, out_valid && !out_stall && panic, !out_valid || running == $past(running), "running thread changed while halted")

  // A spawn never reads ticks and a tick read never spawns.
  `FTS_ASSERT_NOW(ast_one_payload, out_valid, new_thread == 2'd0 || ticks == 16'd0, "spawn slot and tick count both nonzero")

  `FTS_ASSERT_NEXT(ast_out_hold, out_valid && out_stall, out_valid && $stable(running) && $stable(new_thread) && $stable(ticks) && $stable(panic), "stalled result changed")

endmodule

bind fifo_thread_scheduler_with_mutexes fts_checker u_checker (.*);
